/* src/pid_position_controller_macros.svh */
// ----------------------------------------------------------------------------
// pid_position_controller_macros.svh
// Assertion macros for the position controller; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_CONTROLLER_MACROS_SVH
`define PID_POSITION_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define PIDPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PIDPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PIDPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PIDPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* src/pidpc_pkg.sv */
// ----------------------------------------------------------------------------
// pidpc_pkg
// Widths, constants and shared types of the position controller.
// ----------------------------------------------------------------------------
package pidpc_pkg;

    localparam int POS_W  = 16;
    localparam int ERR_W  = 17;
    localparam int GAIN_W = 16;
    localparam int LIM_W  = 16;
    localparam int DRV_W  = 15;
    localparam int DIFF_W = 18;
    localparam int PROD_W = 35;
    localparam int SUM_W  = 37;
    localparam int IDX_W  = 3;

    // divide by 100: magnitudes are saturated first, since any quotient
    // beyond the drive range clamps the same way
    localparam int MAG_W    = 21;
    localparam int RECIP_W  = 22;
    localparam int RECIP_SH = 28;
    localparam int QUO_W    = 15;
    localparam logic [MAG_W-1:0]   SAT_MAG = 21'd1638400;  // 100 * 16384
    localparam logic [RECIP_W-1:0] RECIP   = 22'd2684355;  // ceil(2^28 / 100)

    // pipeline stages
    localparam int ST_A   = 0;  // input register
    localparam int ST_B   = 1;  // error, integral, derivative
    localparam int ST_C   = 2;  // products
    localparam int ST_D   = 3;  // sum
    localparam int ST_E   = 4;  // magnitude and saturation
    localparam int ST_F   = 5;  // scaled quotient
    localparam int ST_G   = 6;  // clamp, result register
    localparam int NUM_ST = 7;

    typedef enum logic [IDX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_INT_ZONE  = 3'd3,
        REG_INT_LIMIT = 3'd4,
        REG_DRIVE_MAX = 3'd5,
        REG_DRIVE_MIN = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i;
        logic [GAIN_W-1:0]       gain_d;
        logic [LIM_W-1:0]        integral_zone;
        logic [LIM_W-1:0]        integral_limit;
        logic signed [DRV_W-1:0] drive_max;
        logic signed [DRV_W-1:0] drive_min;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gain_p:         16'd550,
        gain_i:         16'd10,
        gain_d:         16'd0,
        integral_zone:  16'd200,
        integral_limit: 16'd4000,
        drive_max:      15'sd12000,
        drive_min:      -15'sd12000
    };

    typedef struct packed {
        logic [NUM_ST-1:0] ld;   // stage takes an item this cycle
        logic [NUM_ST-1:0] vld;  // stage holds an item
    } t_pipe_ctl;

endpackage

/* src/pidpc_ctrl.sv */
// ----------------------------------------------------------------------------
// pidpc_ctrl
// Valid bits and ready chain of the pipeline; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module pidpc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_stall,
    output logic                  o_stall,
    output logic                  o_valid,
    output pidpc_pkg::t_pipe_ctl  o_ctl
);

    logic [pidpc_pkg::NUM_ST-1:0] r_vld;
    logic [pidpc_pkg::NUM_ST-1:0] n_vld;
    logic [pidpc_pkg::NUM_ST-1:0] w_ready;
    logic [pidpc_pkg::NUM_ST-1:0] w_vin;

    always_comb begin
        w_ready[pidpc_pkg::NUM_ST-1] = !r_vld[pidpc_pkg::NUM_ST-1] || !i_stall;
        for (int k = pidpc_pkg::NUM_ST - 2; k >= 0; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k+1];
        end
        w_vin = {r_vld[pidpc_pkg::NUM_ST-2:0], i_valid};
        n_vld = (w_ready & w_vin) | (~w_ready & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.ld  = w_ready & w_vin;
    assign o_ctl.vld = r_vld;
    assign o_stall   = !w_ready[pidpc_pkg::ST_A];
    assign o_valid   = r_vld[pidpc_pkg::NUM_ST-1];

endmodule

/* src/pidpc_track.sv */
// ----------------------------------------------------------------------------
// pidpc_track
// Error, zoned and clamped integral, and derivative; holds the loop state.
// ----------------------------------------------------------------------------
module pidpc_track (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_ld,
    input  logic [pidpc_pkg::POS_W-1:0]            i_tgt,
    input  logic [pidpc_pkg::POS_W-1:0]            i_meas,
    input  logic [pidpc_pkg::LIM_W-1:0]            i_zone,
    input  logic [pidpc_pkg::LIM_W-1:0]            i_limit,
    output logic signed [pidpc_pkg::ERR_W-1:0]     o_err,
    output logic signed [pidpc_pkg::ERR_W-1:0]     o_acc,
    output logic signed [pidpc_pkg::DIFF_W-1:0]    o_diff
);

    logic signed [pidpc_pkg::ERR_W-1:0]  r_acc;
    logic signed [pidpc_pkg::ERR_W-1:0]  r_prev;
    logic signed [pidpc_pkg::DIFF_W-1:0] r_diff;

    logic signed [pidpc_pkg::ERR_W-1:0]  w_err;
    logic [pidpc_pkg::ERR_W-1:0]         w_mag;
    logic                                w_in_zone;
    logic signed [pidpc_pkg::DIFF_W-1:0] w_sum;
    logic signed [pidpc_pkg::DIFF_W-1:0] w_pre;
    logic signed [pidpc_pkg::DIFF_W-1:0] w_lim;
    logic signed [pidpc_pkg::DIFF_W-1:0] w_nlim;
    logic signed [pidpc_pkg::DIFF_W-1:0] w_clamp;
    logic signed [pidpc_pkg::DIFF_W-1:0] w_diff;

    always_comb begin
        w_err     = $signed({1'b0, i_tgt}) - $signed({1'b0, i_meas});
        w_mag     = w_err[pidpc_pkg::ERR_W-1] ? -w_err : w_err;
        w_in_zone = (w_mag <= {1'b0, i_zone});
        w_sum     = $signed({r_acc[pidpc_pkg::ERR_W-1], r_acc})
                  + $signed({w_err[pidpc_pkg::ERR_W-1], w_err});
        w_pre     = w_in_zone ? w_sum : '0;
        w_lim     = $signed({2'b00, i_limit});
        w_nlim    = -w_lim;
        if (w_pre > w_lim) begin
            w_clamp = w_lim;
        end else if (w_pre < w_nlim) begin
            w_clamp = w_nlim;
        end else begin
            w_clamp = w_pre;
        end
        // no derivative kick on a zero error
        if (w_err == '0) begin
            w_diff = '0;
        end else begin
            w_diff = $signed({w_err[pidpc_pkg::ERR_W-1], w_err})
                   - $signed({r_prev[pidpc_pkg::ERR_W-1], r_prev});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_prev <= '0;
        end else if (i_ld) begin
            r_acc  <= w_clamp[pidpc_pkg::ERR_W-1:0];
            r_prev <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_diff <= w_diff;
        end
    end

    // the state registers double as this stage's payload
    assign o_err  = r_prev;
    assign o_acc  = r_acc;
    assign o_diff = r_diff;

endmodule

/* src/pidpc_mac.sv */
// ----------------------------------------------------------------------------
// pidpc_mac
// Three gain products in one stage, their sum in the next.
// ----------------------------------------------------------------------------
module pidpc_mac (
    input  logic                                   i_clk,
    input  logic                                   i_ld_prod,
    input  logic                                   i_ld_sum,
    input  logic [pidpc_pkg::GAIN_W-1:0]           i_gain_p,
    input  logic [pidpc_pkg::GAIN_W-1:0]           i_gain_i,
    input  logic [pidpc_pkg::GAIN_W-1:0]           i_gain_d,
    input  logic signed [pidpc_pkg::ERR_W-1:0]     i_err,
    input  logic signed [pidpc_pkg::ERR_W-1:0]     i_acc,
    input  logic signed [pidpc_pkg::DIFF_W-1:0]    i_diff,
    output logic signed [pidpc_pkg::SUM_W-1:0]     o_sum,
    output logic signed [pidpc_pkg::ERR_W-1:0]     o_err
);

    logic signed [pidpc_pkg::PROD_W-1:0] w_prod_p;
    logic signed [pidpc_pkg::PROD_W-1:0] w_prod_i;
    logic signed [pidpc_pkg::PROD_W-1:0] w_prod_d;
    logic signed [pidpc_pkg::PROD_W-1:0] r_prod_p;
    logic signed [pidpc_pkg::PROD_W-1:0] r_prod_i;
    logic signed [pidpc_pkg::PROD_W-1:0] r_prod_d;
    logic signed [pidpc_pkg::ERR_W-1:0]  r_err_c;
    logic signed [pidpc_pkg::SUM_W-1:0]  r_sum;
    logic signed [pidpc_pkg::ERR_W-1:0]  r_err_d;

    assign w_prod_p = $signed({1'b0, i_gain_p}) * i_err;
    assign w_prod_i = $signed({1'b0, i_gain_i}) * i_acc;
    assign w_prod_d = $signed({1'b0, i_gain_d}) * i_diff;

    always_ff @(posedge i_clk) begin
        if (i_ld_prod) begin
            r_prod_p <= w_prod_p;
            r_prod_i <= w_prod_i;
            r_prod_d <= w_prod_d;
            r_err_c  <= i_err;
        end
        if (i_ld_sum) begin
            r_sum   <= pidpc_pkg::SUM_W'(r_prod_p) + pidpc_pkg::SUM_W'(r_prod_i)
                     + pidpc_pkg::SUM_W'(r_prod_d);
            r_err_d <= r_err_c;
        end
    end

    assign o_sum = r_sum;
    assign o_err = r_err_d;

endmodule

/* src/pidpc_scale.sv */
// ----------------------------------------------------------------------------
// pidpc_scale
// Divide by 100 toward zero, then clamp; holds the result register.
// ----------------------------------------------------------------------------
module pidpc_scale (
    input  logic                                   i_clk,
    input  logic                                   i_ld_mag,
    input  logic                                   i_ld_quo,
    input  logic                                   i_ld_out,
    input  logic signed [pidpc_pkg::SUM_W-1:0]     i_sum,
    input  logic signed [pidpc_pkg::ERR_W-1:0]     i_err,
    input  logic signed [pidpc_pkg::DRV_W-1:0]     i_drive_max,
    input  logic signed [pidpc_pkg::DRV_W-1:0]     i_drive_min,
    output logic signed [pidpc_pkg::DRV_W-1:0]     o_drive,
    output logic signed [pidpc_pkg::ERR_W-1:0]     o_err
);

    localparam int SCL_W = pidpc_pkg::MAG_W + pidpc_pkg::RECIP_W;

    logic [pidpc_pkg::SUM_W-1:0]         w_abs;
    logic [pidpc_pkg::MAG_W-1:0]         w_mag;
    logic [SCL_W-1:0]                    w_scaled;
    logic signed [pidpc_pkg::DRV_W:0]    w_quo_s;
    logic signed [pidpc_pkg::DRV_W:0]    w_drv;
    logic signed [pidpc_pkg::DRV_W:0]    w_max;
    logic signed [pidpc_pkg::DRV_W:0]    w_min;
    logic signed [pidpc_pkg::DRV_W:0]    w_hi;
    logic signed [pidpc_pkg::DRV_W:0]    w_res;

    logic [pidpc_pkg::MAG_W-1:0]         r_mag;
    logic                                r_neg_e;
    logic signed [pidpc_pkg::ERR_W-1:0]  r_err_e;
    logic [pidpc_pkg::QUO_W-1:0]         r_quo;
    logic                                r_neg_f;
    logic signed [pidpc_pkg::ERR_W-1:0]  r_err_f;
    logic signed [pidpc_pkg::DRV_W-1:0]  r_drive;
    logic signed [pidpc_pkg::ERR_W-1:0]  r_err_g;

    always_comb begin
        w_abs = i_sum[pidpc_pkg::SUM_W-1] ? -i_sum : i_sum;
        // past the drive range every quotient clamps alike
        if (w_abs > pidpc_pkg::SUM_W'(pidpc_pkg::SAT_MAG)) begin
            w_mag = pidpc_pkg::SAT_MAG;
        end else begin
            w_mag = w_abs[pidpc_pkg::MAG_W-1:0];
        end
        w_scaled = SCL_W'(r_mag) * SCL_W'(pidpc_pkg::RECIP);
        w_quo_s  = $signed({1'b0, r_quo});
        w_drv    = r_neg_f ? -w_quo_s : w_quo_s;
        w_max    = $signed({i_drive_max[pidpc_pkg::DRV_W-1], i_drive_max});
        w_min    = $signed({i_drive_min[pidpc_pkg::DRV_W-1], i_drive_min});
        // upper bound first, lower bound wins when the two cross
        w_hi     = (w_drv > w_max) ? w_max : w_drv;
        w_res    = (w_hi < w_min) ? w_min : w_hi;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_mag) begin
            r_mag   <= w_mag;
            r_neg_e <= i_sum[pidpc_pkg::SUM_W-1];
            r_err_e <= i_err;
        end
        if (i_ld_quo) begin
            r_quo   <= w_scaled[pidpc_pkg::RECIP_SH +: pidpc_pkg::QUO_W];
            r_neg_f <= r_neg_e;
            r_err_f <= r_err_e;
        end
        if (i_ld_out) begin
            r_drive <= w_res[pidpc_pkg::DRV_W-1:0];
            r_err_g <= r_err_f;
        end
    end

    assign o_drive = r_drive;
    assign o_err   = r_err_g;

endmodule

/* src/pid_position_controller.sv */
// ----------------------------------------------------------------------------
// pid_position_controller
// Position PID loop with integral zone, integral clamp and drive clamp.
// ----------------------------------------------------------------------------
// One item is one control tick: a target and a measured position in
// centidegrees. The block returns one item per tick with the clamped drive
// in millivolts and the position error. It takes a new item every clock
// cycle unless o_stall is high; each item passes seven registers (input
// register, error/integral/derivative, gain products, sum, magnitude,
// reciprocal multiply for the divide by 100, clamp), the last of them the
// result register. The integral and previous-error registers update in a
// single stage, so back-to-back ticks see each other's state without a
// hole. Under output stall the stages fill up before the input stalls.
// Configuration registers are written through the plain write port and
// must only change while no item is in flight.
// ----------------------------------------------------------------------------
`include "pid_position_controller_macros.svh"

module pid_position_controller (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [pidpc_pkg::POS_W-1:0]            i_target_position,
    input  logic [pidpc_pkg::POS_W-1:0]            i_measured_position,
    // result channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [pidpc_pkg::DRV_W-1:0]     o_drive_mv,
    output logic signed [pidpc_pkg::ERR_W-1:0]     o_position_error,
    // configuration
    input  logic                                   i_cfg_wr_en,
    input  logic [pidpc_pkg::IDX_W-1:0]            i_cfg_index,
    input  logic [pidpc_pkg::GAIN_W-1:0]           i_cfg_data
);

    pidpc_pkg::t_cfg                     r_cfg;
    pidpc_pkg::t_pipe_ctl                w_ctl;
    logic [pidpc_pkg::POS_W-1:0]         r_tgt;
    logic [pidpc_pkg::POS_W-1:0]         r_meas;
    logic signed [pidpc_pkg::ERR_W-1:0]  w_err_b;
    logic signed [pidpc_pkg::ERR_W-1:0]  w_acc_b;
    logic signed [pidpc_pkg::DIFF_W-1:0] w_diff_b;
    logic signed [pidpc_pkg::SUM_W-1:0]  w_sum_d;
    logic signed [pidpc_pkg::ERR_W-1:0]  w_err_d;

    // configuration registers; unknown indexes drop the write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pidpc_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pidpc_pkg::REG_GAIN_P: begin
                    r_cfg.gain_p <= i_cfg_data;
                end
                pidpc_pkg::REG_GAIN_I: begin
                    r_cfg.gain_i <= i_cfg_data;
                end
                pidpc_pkg::REG_GAIN_D: begin
                    r_cfg.gain_d <= i_cfg_data;
                end
                pidpc_pkg::REG_INT_ZONE: begin
                    r_cfg.integral_zone <= i_cfg_data;
                end
                pidpc_pkg::REG_INT_LIMIT: begin
                    r_cfg.integral_limit <= i_cfg_data;
                end
                pidpc_pkg::REG_DRIVE_MAX: begin
                    r_cfg.drive_max <= $signed(i_cfg_data[pidpc_pkg::DRV_W-1:0]);
                end
                pidpc_pkg::REG_DRIVE_MIN: begin
                    r_cfg.drive_min <= $signed(i_cfg_data[pidpc_pkg::DRV_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline handshake
    pidpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctl   (w_ctl)
    );

    // input register: hold the accepted item
    always_ff @(posedge i_clk) begin
        if (w_ctl.ld[pidpc_pkg::ST_A]) begin
            r_tgt  <= i_target_position;
            r_meas <= i_measured_position;
        end
    end

    // error, integral and derivative; the loop state lives here
    pidpc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_ctl.ld[pidpc_pkg::ST_B]),
        .i_tgt   (r_tgt),
        .i_meas  (r_meas),
        .i_zone  (r_cfg.integral_zone),
        .i_limit (r_cfg.integral_limit),
        .o_err   (w_err_b),
        .o_acc   (w_acc_b),
        .o_diff  (w_diff_b)
    );

    // weighted sum of the three terms
    pidpc_mac u_mac (
        .i_clk     (i_clk),
        .i_ld_prod (w_ctl.ld[pidpc_pkg::ST_C]),
        .i_ld_sum  (w_ctl.ld[pidpc_pkg::ST_D]),
        .i_gain_p  (r_cfg.gain_p),
        .i_gain_i  (r_cfg.gain_i),
        .i_gain_d  (r_cfg.gain_d),
        .i_err     (w_err_b),
        .i_acc     (w_acc_b),
        .i_diff    (w_diff_b),
        .o_sum     (w_sum_d),
        .o_err     (w_err_d)
    );

    // scale to millivolts, clamp and drive the result register
    pidpc_scale u_scale (
        .i_clk       (i_clk),
        .i_ld_mag    (w_ctl.ld[pidpc_pkg::ST_E]),
        .i_ld_quo    (w_ctl.ld[pidpc_pkg::ST_F]),
        .i_ld_out    (w_ctl.ld[pidpc_pkg::ST_G]),
        .i_sum       (w_sum_d),
        .i_err       (w_err_d),
        .i_drive_max (r_cfg.drive_max),
        .i_drive_min (r_cfg.drive_min),
        .o_drive     (o_drive_mv),
        .o_err       (o_position_error)
    );

    // input stalls only once every stage holds an item
    `PIDPC_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, &w_ctl.vld, "stall with a free stage")
    // loop state moves only when an item enters the state stage
    `PIDPC_ASSERT_NXT(a_state_hold, i_clk, i_rst_n, !w_ctl.ld[pidpc_pkg::ST_B], $stable(w_acc_b) && $stable(w_err_b), "loop state changed without an item")
    // a zero error carries a zero derivative
    `PIDPC_ASSERT_NXT(a_zero_diff, i_clk, i_rst_n, w_ctl.ld[pidpc_pkg::ST_B], (w_err_b != '0) || (w_diff_b == '0), "derivative not zero on zero error")

endmodule
